### rtl/core/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types, codes and widths for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BLOCKS_DEF  = 64;
    localparam int ALIGN_BYTES_DEF = 8;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int REQ_W   = 24;
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 25;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 32;
    localparam int PADDR_W = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ARG  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 2'd3;

    // Register indexes (paddr[2])
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_BYTES = 1'b1;

    localparam logic [CFG_W-1:0] HEAP_BASE_RST  = 32'd0;
    localparam logic [CFG_W-1:0] HEAP_BYTES_RST = 32'd1048576;

    // One block table entry
    typedef struct packed {
        logic              free;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/core/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit block allocator with an APB register port for the heap window.
// ----------------------------------------------------------------------------
// Each beat on the input channel is one operation (reserve, release or size
// query) and produces exactly one result beat. Reserve rounds the size up to
// ALIGN_BYTES, reuses the smallest free block that fits (earliest on a tie)
// or appends a new block from a bump pointer inside [heap_base,
// heap_base + heap_bytes). Release and query match the earliest block with
// the given address. The block table is a single-port memory read once per
// cycle, so every operation walks the whole table: each item passes through
// size alignment (multiply, quotient, fix), a scan of every entry, a commit
// that waits while the result register is stalled, and a return to accept.
// A finished result may wait in the output register while the next item is
// taken.
// Registers: 0x0 heap_base, 0x4 heap_bytes; write only while idle.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
    parameter int MAX_BLOCKS  = bfba_pkg::MAX_BLOCKS_DEF,
    parameter int ALIGN_BYTES = bfba_pkg::ALIGN_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfba_pkg::PADDR_W-1:0]   paddr,
    input  logic [bfba_pkg::CFG_W-1:0]     pwdata,
    output logic [bfba_pkg::CFG_W-1:0]     prdata,
    output logic                           pready,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bfba_pkg::OP_W-1:0]      i_operation,
    input  logic [bfba_pkg::REQ_W-1:0]     i_request_size,
    input  logic [bfba_pkg::ADDR_W-1:0]    i_block_addr_in,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bfba_pkg::STAT_W-1:0]    o_status,
    output logic [bfba_pkg::ADDR_W-1:0]    o_granted_addr,
    output logic [bfba_pkg::SIZE_W-1:0]    o_block_bytes
);

    logic [bfba_pkg::CFG_W-1:0] r_heap_base;
    logic [bfba_pkg::CFG_W-1:0] r_heap_bytes;
    logic                       w_cfg_wr;
    logic                       w_reg_idx;

    bfba_pkg::t_dp_cmd          w_cmd;
    bfba_pkg::t_dp_stat         w_stat;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= bfba_pkg::HEAP_BASE_RST;
            r_heap_bytes <= bfba_pkg::HEAP_BYTES_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                bfba_pkg::REG_HEAP_BASE:  r_heap_base  <= pwdata;
                bfba_pkg::REG_HEAP_BYTES: r_heap_bytes <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            bfba_pkg::REG_HEAP_BASE:  prdata = r_heap_base;
            bfba_pkg::REG_HEAP_BYTES: prdata = r_heap_bytes;
            default:                  prdata = '0;
        endcase
    end

    bfba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    bfba_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_operation     (i_operation),
        .i_request_size  (i_request_size),
        .i_block_addr_in (i_block_addr_in),
        .i_heap_base     (r_heap_base),
        .i_heap_bytes    (r_heap_bytes),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_granted_addr  (o_granted_addr),
        .o_block_bytes   (o_block_bytes)
    );

endmodule

### rtl/core/bfba_ctrl.sv
// ----------------------------------------------------------------------------
// bfba_ctrl
// Sequencer: accept, size alignment, table scan, commit of one result.
// ----------------------------------------------------------------------------
module bfba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  bfba_pkg::t_dp_stat i_stat,
    output bfba_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_ALN_MUL = 6'b000010,
        S_ALN_QUO = 6'b000100,
        S_ALN_FIX = 6'b001000,
        S_SCAN    = 6'b010000,
        S_FINISH  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ALN_MUL;
                end
            end
            S_ALN_MUL: n_state = S_ALN_QUO;
            S_ALN_QUO: n_state = S_ALN_FIX;
            S_ALN_FIX: begin
                o_cmd.scan_start = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait for the output register to drain
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

### rtl/core/bfba_dp.sv
// ----------------------------------------------------------------------------
// bfba_dp
// Block table memory, size alignment, best-fit / lookup scan, result register.
// ----------------------------------------------------------------------------
module bfba_dp #(
    parameter int MAX_BLOCKS  = bfba_pkg::MAX_BLOCKS_DEF,
    parameter int ALIGN_BYTES = bfba_pkg::ALIGN_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfba_pkg::t_dp_cmd             i_cmd,
    output bfba_pkg::t_dp_stat            o_stat,
    input  logic [bfba_pkg::OP_W-1:0]     i_operation,
    input  logic [bfba_pkg::REQ_W-1:0]    i_request_size,
    input  logic [bfba_pkg::ADDR_W-1:0]   i_block_addr_in,
    input  logic [bfba_pkg::CFG_W-1:0]    i_heap_base,
    input  logic [bfba_pkg::CFG_W-1:0]    i_heap_bytes,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bfba_pkg::STAT_W-1:0]   o_status,
    output logic [bfba_pkg::ADDR_W-1:0]   o_granted_addr,
    output logic [bfba_pkg::SIZE_W-1:0]   o_block_bytes
);

    localparam int SIZE_W = bfba_pkg::SIZE_W;
    localparam int ADDR_W = bfba_pkg::ADDR_W;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

    // ceil to alignment: q ~ x * floor(2^31 / A) >> 31, then one correction step
    localparam int          RCP_SH = 31;
    localparam logic [31:0] RCP    = 32'((64'd1 << RCP_SH) / ALIGN_BYTES);
    localparam int          PROD_W = SIZE_W + 32;
    localparam int          QUO_W  = PROD_W - RCP_SH;
    localparam logic [SIZE_W-1:0] ALN_C  = SIZE_W'(ALIGN_BYTES);
    localparam logic [SIZE_W-1:0] ALN_M1 = SIZE_W'(ALIGN_BYTES - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);

    // captured item
    logic [bfba_pkg::OP_W-1:0]   r_op;
    logic [bfba_pkg::REQ_W-1:0]  r_req;
    logic [ADDR_W-1:0]           r_addr;

    // alignment pipeline
    logic [SIZE_W-1:0]           w_x;
    logic [PROD_W-1:0]           r_prod;
    logic [QUO_W-1:0]            w_quo;
    logic [QUO_W+SIZE_W-1:0]     w_qa_full;
    logic [SIZE_W-1:0]           r_qa;
    logic [SIZE_W-1:0]           w_rem;
    logic [SIZE_W-1:0]           r_aligned;

    // table and scan
    bfba_pkg::t_entry            r_mem [MAX_BLOCKS];
    bfba_pkg::t_entry            r_rd_data;
    logic [CNT_W-1:0]            r_rd_idx;
    logic                        r_rd_vld;
    logic [IDX_W-1:0]            r_cmp_idx;
    logic                        w_rd_go;
    logic                        w_fit;
    logic                        w_match;
    logic                        w_take;
    logic                        r_sel_vld;
    logic [IDX_W-1:0]            r_sel_idx;
    logic [SIZE_W-1:0]           r_sel_size;
    logic [ADDR_W-1:0]           r_sel_addr;

    // allocator state
    logic [CNT_W-1:0]            r_count;
    logic [ADDR_W-1:0]           r_bump;
    logic [ADDR_W:0]             w_end;

    // commit decision
    logic                        w_wr_en;
    logic [IDX_W-1:0]            w_wr_idx;
    bfba_pkg::t_entry            w_wr_data;
    logic                        w_append;
    logic [bfba_pkg::STAT_W-1:0] w_status;
    logic [ADDR_W-1:0]           w_gaddr;
    logic [SIZE_W-1:0]           w_bytes;

    // result register
    logic                        r_out_vld;
    logic [bfba_pkg::STAT_W-1:0] r_status;
    logic [ADDR_W-1:0]           r_gaddr;
    logic [SIZE_W-1:0]           r_bytes;
    logic                        w_out_free;

    // ---------------- capture ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_req  <= i_request_size;
            r_addr <= i_block_addr_in;
        end
    end

    // ---------------- alignment ----------------
    assign w_x       = {1'b0, r_req} + ALN_M1;
    assign w_quo     = r_prod[PROD_W-1:RCP_SH];
    assign w_qa_full = w_quo * ALN_C;
    assign w_rem     = w_x - r_qa;

    always_ff @(posedge i_clk) begin
        r_prod    <= w_x * RCP;
        r_qa      <= w_qa_full[SIZE_W-1:0];
        r_aligned <= (w_rem >= ALN_C) ? (r_qa + ALN_C) : r_qa;
    end

    // ---------------- scan ----------------
    assign w_rd_go = (r_rd_idx < r_count);

    assign w_fit   = r_rd_data.free && (r_rd_data.size >= r_aligned) &&
                     (!r_sel_vld || (r_rd_data.size < r_sel_size));
    // first match wins
    assign w_match = (r_rd_data.addr == r_addr) && !r_sel_vld;
    assign w_take  = r_rd_vld && ((r_op == bfba_pkg::OP_RESERVE) ? w_fit : w_match);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && w_rd_go) begin
            r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (w_take) begin
            r_sel_idx  <= r_cmp_idx;
            r_sel_size <= r_rd_data.size;
            r_sel_addr <= r_rd_data.addr;
        end
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_sel_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_sel_vld <= 1'b0;
        end else begin
            if (i_cmd.scan_step) begin
                r_rd_vld <= w_rd_go;
                if (w_rd_go) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (w_take) begin
                r_sel_vld <= 1'b1;
            end
        end
    end

    assign o_stat.scan_done = !r_rd_vld && !w_rd_go;

    // ---------------- decision ----------------
    assign w_end = {1'b0, r_bump} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, r_aligned};

    always_comb begin
        w_status  = bfba_pkg::ST_OK;
        w_gaddr   = '0;
        w_bytes   = '0;
        w_append  = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_idx  = r_sel_idx;
        w_wr_data = '{free: 1'b0, addr: r_sel_addr, size: r_sel_size};
        unique case (r_op)
            bfba_pkg::OP_RESERVE: begin
                priority if (r_req == '0) begin
                    w_status = bfba_pkg::ST_BAD_ARG;
                end else if (r_sel_vld) begin
                    w_wr_en = 1'b1;
                    w_gaddr = r_sel_addr;
                    w_bytes = r_sel_size;
                end else if (r_count >= CNT_MAX) begin
                    w_status = bfba_pkg::ST_NO_SPACE;
                end else if (w_end > {1'b0, i_heap_bytes}) begin
                    w_status = bfba_pkg::ST_NO_SPACE;
                end else begin
                    w_append  = 1'b1;
                    w_wr_en   = 1'b1;
                    w_wr_idx  = r_count[IDX_W-1:0];
                    w_wr_data = '{free: 1'b0, addr: i_heap_base + r_bump,
                                  size: r_aligned};
                    w_gaddr   = i_heap_base + r_bump;
                    w_bytes   = r_aligned;
                end
            end
            bfba_pkg::OP_RELEASE, bfba_pkg::OP_QUERY: begin
                priority if (r_addr == '0) begin
                    w_status = bfba_pkg::ST_BAD_ARG;
                end else if (!r_sel_vld) begin
                    w_status = bfba_pkg::ST_UNKNOWN;
                end else if (r_op == bfba_pkg::OP_RELEASE) begin
                    w_wr_en        = 1'b1;
                    w_wr_data.free = 1'b1;
                end else begin
                    w_bytes = r_sel_size;
                end
            end
            default: w_status = bfba_pkg::ST_BAD_ARG;
        endcase
        w_wr_en = w_wr_en && i_cmd.commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bump  <= '0;
        end else if (i_cmd.commit && w_append) begin
            r_count <= r_count + 1'b1;
            r_bump  <= w_end[ADDR_W-1:0];
        end
    end

    // ---------------- result register ----------------
    assign w_out_free      = !r_out_vld || !i_stall;
    assign o_stat.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= w_status;
            r_gaddr  <= w_gaddr;
            r_bytes  <= w_bytes;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_status;
    assign o_granted_addr = r_gaddr;
    assign o_block_bytes  = r_bytes;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("block count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + 1'b1))
        else $error("block count moved by more than one");

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> w_out_free)
        else $error("commit while result register occupied");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_vld)
        else $error("commit did not present a result");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ({{(CNT_W - IDX_W){1'b0}}, r_cmp_idx} < r_count))
        else $error("compared entry beyond block count");
`endif

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for best_fit_block_allocator. Operations go in through
// a queue-fed driver and are predicted on acceptance. Results are checked in
// order, field by field. The heap window is reprogrammed between phases.
// ----------------------------------------------------------------------------
module testbench;
    import bfba_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF   = 2'd3;
    localparam int              CYCLE_LIMIT = 1000000;
    localparam int              TAIL_CYCLES = 80;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
    } alloc_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] bytes;
    } alloc_reply_t;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [PADDR_W-1:0]  paddr           = '0;
    logic [CFG_W-1:0]    pwdata          = '0;
    logic [CFG_W-1:0]    prdata;
    logic                pready;
    logic                i_valid         = 1'b0;
    logic                o_stall;
    logic [OP_W-1:0]     i_operation     = '0;
    logic [REQ_W-1:0]    i_request_size  = '0;
    logic [ADDR_W-1:0]   i_block_addr_in = '0;
    logic                o_valid;
    logic                i_stall         = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [ADDR_W-1:0]   o_granted_addr;
    logic [SIZE_W-1:0]   o_block_bytes;

    // predictor state
    logic [ADDR_W-1:0]   blk_addr [MAX_BLOCKS_DEF];
    logic [SIZE_W-1:0]   blk_size [MAX_BLOCKS_DEF];
    logic                blk_free [MAX_BLOCKS_DEF];
    int                  blk_count = 0;
    logic [ADDR_W-1:0]   bump_ptr  = '0;
    logic [CFG_W-1:0]    heap_base  = HEAP_BASE_RST;
    logic [CFG_W-1:0]    heap_limit = HEAP_BYTES_RST;

    alloc_req_t          alloc_backlog[$];
    alloc_reply_t        expected_replies[$];
    int                  fail_cnt     = 0;
    int                  accepted_cnt = 0;
    int                  cycle_cnt    = 0;
    logic                rx_hold      = 1'b0;

    best_fit_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_request_size (i_request_size),
        .i_block_addr_in(i_block_addr_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_granted_addr (o_granted_addr),
        .o_block_bytes  (o_block_bytes)
    );

    always #4 i_clk = ~i_clk;

    // Best fit over the table, earliest wins a tie; bump append otherwise.
    function automatic alloc_reply_t predict_alloc(input alloc_req_t rq);
        alloc_reply_t      res;
        logic [SIZE_W-1:0] aligned;
        logic [ADDR_W:0]   top;
        int                best;
        int                hit;
        res  = '0;
        best = -1;
        hit  = -1;
        case (rq.op)
            OP_RESERVE: begin
                if (rq.req == '0) begin
                    res.status = ST_BAD_ARG;
                end else begin
                    aligned = SIZE_W'(((longint'(rq.req) + ALIGN_BYTES_DEF - 1)
                                       / ALIGN_BYTES_DEF) * ALIGN_BYTES_DEF);
                    for (int i = 0; i < blk_count; i++) begin
                        if (blk_free[i] && blk_size[i] >= aligned &&
                            (best < 0 || blk_size[i] < blk_size[best]))
                            best = i;
                    end
                    if (best < 0) begin
                        top = {1'b0, bump_ptr} + aligned;
                        if (blk_count >= MAX_BLOCKS_DEF || top > {1'b0, heap_limit}) begin
                            res.status = ST_NO_SPACE;
                        end else begin
                            best           = blk_count;
                            blk_addr[best] = heap_base + bump_ptr;
                            blk_size[best] = aligned;
                            blk_count++;
                            bump_ptr       = top[ADDR_W-1:0];
                        end
                    end
                    if (best >= 0) begin
                        blk_free[best] = 1'b0;
                        res.status     = ST_OK;
                        res.addr       = blk_addr[best];
                        res.bytes      = blk_size[best];
                    end
                end
            end
            OP_RELEASE, OP_QUERY: begin
                if (rq.addr == '0) begin
                    res.status = ST_BAD_ARG;
                end else begin
                    for (int i = blk_count - 1; i >= 0; i--)
                        if (blk_addr[i] == rq.addr) hit = i;
                    if (hit < 0)
                        res.status = ST_UNKNOWN;
                    else if (rq.op == OP_RELEASE)
                        blk_free[hit] = 1'b1;
                    else
                        res.bytes = blk_size[hit];
                end
            end
            default: res.status = ST_BAD_ARG;
        endcase
        return res;
    endfunction

    // request driver
    int   send_gap   = 0;
    logic send_burst = 1'b0;
    always @(posedge i_clk) begin
        alloc_req_t rq;
        logic       fire;
        logic       nxt_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            fire = i_valid && !o_stall;
            if (fire) begin
                rq.op   = i_operation;
                rq.req  = i_request_size;
                rq.addr = i_block_addr_in;
                expected_replies.push_back(predict_alloc(rq));
                accepted_cnt++;
            end
            if (!i_valid || fire) begin
                nxt_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (alloc_backlog.size() != 0) begin
                    rq              = alloc_backlog.pop_front();
                    i_operation     <= rq.op;
                    i_request_size  <= rq.req;
                    i_block_addr_in <= rq.addr;
                    nxt_valid       = 1'b1;
                    if ($urandom_range(0, 31) == 0) send_burst = ~send_burst;
                    send_gap = send_burst ? 0 : int'($urandom_range(0, 18));
                end
                i_valid <= nxt_valid;
            end
        end
    end

    // result monitor and stall generator
    int   recv_wait  = 0;
    logic recv_burst = 1'b0;
    always @(posedge i_clk) begin
        alloc_reply_t got;
        alloc_reply_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_status, o_granted_addr, o_block_bytes};
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected beat: status %0d addr %h bytes %h",
                             $time, got.status, got.addr, got.bytes);
                    fail_cnt++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status || got.addr !== want.addr ||
                        got.bytes !== want.bytes) begin
                        $display("%0t: mismatch: expected status %0d addr %h bytes %h",
                                 $time, want.status, want.addr, want.bytes);
                        $display("%0t:           actual   status %0d addr %h bytes %h",
                                 $time, got.status, got.addr, got.bytes);
                        fail_cnt++;
                    end
                end
                if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
                recv_wait = recv_burst ? 0 : int'($urandom_range(0, 18));
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            i_stall <= rx_hold || (recv_wait > 0);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (accepted_cnt >= 500);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_op(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                           input logic [ADDR_W-1:0] addr);
        alloc_req_t rq;
        rq.op   = op;
        rq.req  = req;
        rq.addr = addr;
        alloc_backlog.push_back(rq);
    endtask

    task automatic wait_idle();
        while (alloc_backlog.size() != 0 || i_valid || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_HEAP_BASE) heap_base = value;
        else heap_limit = value;
    endtask

    function automatic logic [ADDR_W-1:0] known_addr();
        if (blk_count == 0) return $urandom;
        return blk_addr[$urandom_range(0, blk_count - 1)];
    endfunction

    // mostly small reserves and release/query of live addresses, some noise
    task automatic random_phase(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            while (alloc_backlog.size() >= 2) @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 40)
                push_op(OP_RESERVE,
                        ($urandom_range(0, 9) == 0) ? REQ_W'($urandom_range(1, 4096))
                                                    : REQ_W'($urandom_range(1, 256)),
                        $urandom);
            else if (r < 68)
                push_op(OP_RELEASE, REQ_W'($urandom), known_addr());
            else if (r < 85)
                push_op(OP_QUERY, REQ_W'($urandom), known_addr());
            else
                push_op(OP_W'($urandom_range(0, 3)), REQ_W'($urandom),
                        $urandom_range(0, 1) ? $urandom : known_addr());
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset heap window: zero size, block at address zero, reuse of a larger block
        push_op(OP_RESERVE, 24'd0,        32'd0);
        push_op(OP_RESERVE, 24'd1,        32'd0);
        push_op(OP_RELEASE, 24'd0,        32'd0);
        push_op(OP_QUERY,   24'd0,        32'd0);
        push_op(OP_UNDEF,   24'hFF_FFFF,  32'hFFFF_FFFF);
        push_op(OP_RESERVE, 24'd16,       32'd0);
        push_op(OP_QUERY,   24'd0,        32'd8);
        push_op(OP_RELEASE, 24'hFF_FFFF,  32'd8);
        push_op(OP_RELEASE, 24'd0,        32'd8);
        push_op(OP_RESERVE, 24'd9,        32'd0);
        push_op(OP_QUERY,   24'd0,        32'h1234);
        push_op(OP_RESERVE, 24'hFF_FFFF,  32'd0);
        push_op(OP_RELEASE, 24'd0,        32'hFFFF_FFFF);
        wait_idle();

        // base near the top: address wraps onto an existing block
        apb_write(REG_HEAP_BASE,  32'hFFFF_FFF0);
        apb_write(REG_HEAP_BYTES, 32'hFFFF_FFFF);
        push_op(OP_RESERVE, 24'hFF_FFFF,  32'd0);
        push_op(OP_QUERY,   24'd0,        32'd8);
        push_op(OP_RESERVE, 24'd8,        32'd0);
        push_op(OP_RELEASE, 24'd0,        32'h0100_0008);
        push_op(OP_QUERY,   24'd0,        32'h0100_0008);
        wait_idle();

        // heap shrunk below the bump pointer
        apb_write(REG_HEAP_BYTES, 32'd0);
        push_op(OP_RESERVE, 24'd100,      32'd0);
        push_op(OP_RESERVE, 24'd5,        32'd0);
        push_op(OP_UNDEF,   24'd0,        32'd0);
        wait_idle();

        apb_write(REG_HEAP_BASE,  $urandom & ~32'd7);
        apb_write(REG_HEAP_BYTES, bump_ptr + 32'd4096);
        random_phase(258);
        wait_idle();

        apb_write(REG_HEAP_BASE,  $urandom);
        apb_write(REG_HEAP_BYTES, 32'hFFFF_FFFF);
        random_phase(258);
        wait_idle();

        apb_write(REG_HEAP_BASE,  32'd0);
        apb_write(REG_HEAP_BYTES, bump_ptr + 32'd512);
        random_phase(258);
        wait_idle();

        apb_write(REG_HEAP_BASE,  32'hFFFF_FFFF);
        apb_write(REG_HEAP_BYTES, 32'd0);
        random_phase(258);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && expected_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/core/bfba_pkg.sv
rtl/core/bfba_ctrl.sv
rtl/core/bfba_dp.sv
rtl/core/best_fit_block_allocator.sv
bench/testbench.sv
